@@ src/vpr_pkg.sv @@
// ----------------------------------------------------------------------------
// vpr_pkg: shared types and constants for the velocity profile ramp
// Step codes from controller to datapath, status back, fixed-point constants.
// ----------------------------------------------------------------------------
package vpr_pkg;

  // step time limit, 0.1 s in unsigned Q0.24
  localparam logic [20:0] DT_LIMIT = 21'd1677722;
  // 0.001 in Q16.16
  localparam logic signed [33:0] SMALL_Q16 = 34'sd66;
  // pi in Q30
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [63:0] PI_Q30_W = 64'd3373259426;
  localparam logic [63:0] ONE_Q30_W = 64'd1073741824;
  localparam logic [47:0] LEN_MAX = '1;

  // register indexes
  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_ACCEL  = 3'd1;
  localparam logic [2:0] CFG_JERK   = 3'd2;
  localparam logic [2:0] CFG_SPEED  = 3'd3;
  localparam logic [2:0] CFG_PERIOD = 3'd4;

  // profile codes; the spare code runs as a trapezoid
  localparam logic [1:0] MODE_TRAP     = 2'd0;
  localparam logic [1:0] MODE_COSINE   = 2'd1;
  localparam logic [1:0] MODE_SCURVE   = 2'd2;
  localparam logic [1:0] MODE_TRAP_ALT = 2'd3;

  typedef enum logic [4:0] {
    ST_NONE, ST_LATCH, ST_DT_MUL, ST_DT_SAT, ST_T_MUL, ST_TRAP,
    ST_J_MUL, ST_J_ACC, ST_D_MUL, ST_S_NV, ST_C_CHK, ST_L_MUL,
    ST_L_DIV, ST_L_SET, ST_C_ADV, ST_C_CMP, ST_P_DIV, ST_C_INT,
    ST_C_W, ST_C_MAG, ST_C_NV, ST_LIMIT
  } step_t;

  typedef struct packed {
    step_t step;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic       dt_zero;
    logic [1:0] mode;
    logic       jerk_zero;
    logic       accel_zero;
    logic       restart;
    logic       dv_small;
    logic       len_zero;
    logic       el_done;
    logic       div_done;
  } stat_t;

endpackage

@@ src/vpr_div.sv @@
// ----------------------------------------------------------------------------
// vpr_div: restoring divider
// One quotient bit per cycle, with done raised after the last bit.
// ----------------------------------------------------------------------------
module vpr_div #(
  parameter int DVD_W = 73,
  parameter int DVS_W = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] sh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial    = {rem, sh[DVD_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
        rem  <= '0;
        sh   <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        sh  <= {sh[DVD_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/vpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// vpr_ctrl: sequencer for one ramp update
// Walks the datapath through the steps of the selected profile.
// ----------------------------------------------------------------------------
module vpr_ctrl
  import vpr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  output logic  m_tvalid,
  input  logic  m_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DT_MUL, S_DT_SAT, S_T_MUL, S_TRAP, S_J_MUL, S_J_ACC,
    S_D_MUL, S_S_NV, S_C_CHK, S_L_MUL, S_L_DIV, S_L_WAIT, S_L_SET,
    S_C_ADV, S_C_CMP, S_P_DIV, S_P_WAIT, S_C_INT, S_C_W, S_C_MAG,
    S_C_NV, S_LIMIT, S_OUT
  } state_t;

  state_t state;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd.out_load = 1'b0;
    unique case (state)
      S_IDLE:   cmd.step = s_tvalid ? ST_LATCH : ST_NONE;
      S_DT_MUL: cmd.step = ST_DT_MUL;
      S_DT_SAT: cmd.step = ST_DT_SAT;
      S_T_MUL:  cmd.step = ST_T_MUL;
      S_TRAP:   cmd.step = ST_TRAP;
      S_J_MUL:  cmd.step = ST_J_MUL;
      S_J_ACC:  cmd.step = ST_J_ACC;
      S_D_MUL:  cmd.step = ST_D_MUL;
      S_S_NV:   cmd.step = ST_S_NV;
      S_C_CHK:  cmd.step = ST_C_CHK;
      S_L_MUL:  cmd.step = ST_L_MUL;
      S_L_DIV:  cmd.step = ST_L_DIV;
      S_L_SET:  cmd.step = ST_L_SET;
      S_C_ADV:  cmd.step = ST_C_ADV;
      S_C_CMP:  cmd.step = ST_C_CMP;
      S_P_DIV:  cmd.step = ST_P_DIV;
      S_C_INT:  cmd.step = ST_C_INT;
      S_C_W:    cmd.step = ST_C_W;
      S_C_MAG:  cmd.step = ST_C_MAG;
      S_C_NV:   cmd.step = ST_C_NV;
      S_LIMIT:  cmd.step = ST_LIMIT;
      S_OUT: begin
        cmd.step     = ST_NONE;
        cmd.out_load = out_free;
      end
      default:  cmd.step = ST_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE:   if (s_tvalid) state <= S_DT_MUL;
        S_DT_MUL: state <= S_DT_SAT;
        S_DT_SAT: begin
          if (stat.dt_zero) state <= S_OUT;
          else if (stat.mode == MODE_COSINE) state <= S_C_CHK;
          else if (stat.mode == MODE_SCURVE && !stat.jerk_zero) state <= S_J_MUL;
          else state <= S_T_MUL;
        end
        S_T_MUL:  state <= S_TRAP;
        S_TRAP:   state <= S_LIMIT;
        S_J_MUL:  state <= S_J_ACC;
        S_J_ACC:  state <= S_D_MUL;
        S_D_MUL:  state <= S_S_NV;
        S_S_NV:   state <= S_LIMIT;
        S_C_CHK: begin
          if (stat.restart && !stat.dv_small && !stat.accel_zero) state <= S_L_MUL;
          else state <= S_C_ADV;
        end
        S_L_MUL:  state <= S_L_DIV;
        S_L_DIV:  state <= S_L_WAIT;
        S_L_WAIT: if (stat.div_done) state <= S_L_SET;
        S_L_SET:  state <= S_C_ADV;
        S_C_ADV:  state <= stat.len_zero ? S_LIMIT : S_C_CMP;
        S_C_CMP:  state <= stat.el_done ? S_LIMIT : S_P_DIV;
        S_P_DIV:  state <= S_P_WAIT;
        S_P_WAIT: if (stat.div_done) state <= S_C_INT;
        S_C_INT:  state <= S_C_W;
        S_C_W:    state <= S_C_MAG;
        S_C_MAG:  state <= S_C_NV;
        S_C_NV:   state <= S_LIMIT;
        S_LIMIT:  state <= S_OUT;
        S_OUT:    if (out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/vpr_dp.sv @@
// ----------------------------------------------------------------------------
// vpr_dp: ramp datapath
// Config and profile state, one shared multiplier, divider, blend table.
// ----------------------------------------------------------------------------
module vpr_dp
  import vpr_pkg::*;
#(
  parameter int COS_TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [47:0] in_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic [31:0] out_data
);

  localparam int CW    = $clog2(COS_TABLE_ENTRIES + 1);
  localparam int PW    = 48 + CW;
  localparam int DVD_W = PW + 16;
  localparam int DVS_W = 48;
  localparam logic [PW-1:0] N_MUL = PW'(COS_TABLE_ENTRIES);
  localparam logic [CW-1:0] IDX_LAST = CW'(COS_TABLE_ENTRIES - 1);
  localparam logic signed [33:0] NV_MAX = 34'sd2147483647;
  localparam logic signed [33:0] NV_MIN = -34'sd2147483648;

  // blend weight table, (1 - cos(pi*k/N)) / 2 in Q30
  logic [31:0] wtab [0:COS_TABLE_ENTRIES];
  for (genvar k = 0; k <= COS_TABLE_ENTRIES; k++) begin : g_wtab
    localparam logic [63:0] KK = (2 * k <= COS_TABLE_ENTRIES) ? k : COS_TABLE_ENTRIES - k;
    localparam logic [63:0] X  = (PI_Q30_W * KK) / (2 * COS_TABLE_ENTRIES);
    localparam logic [63:0] T1 = ((((X * X) >> 30) * X) >> 30) / 6;
    localparam logic [63:0] T2 = ((((T1 * X) >> 30) * X) >> 30) / 20;
    localparam logic [63:0] T3 = ((((T2 * X) >> 30) * X) >> 30) / 42;
    localparam logic [63:0] T4 = ((((T3 * X) >> 30) * X) >> 30) / 72;
    localparam logic [63:0] S  = X - T1 + T2 - T3 + T4;
    localparam logic [63:0] LW = (S * S) >> 30;
    localparam logic [63:0] W  = (2 * k <= COS_TABLE_ENTRIES) ? LW : ONE_Q30_W - LW;
    assign wtab[k] = W[31:0];
  end

  // config
  logic [1:0]  mode;
  logic [30:0] accel_lim, jerk_lim, speed_lim;
  logic [23:0] tick_period;

  // item and profile state
  logic signed [31:0] tgt, speed, accel, bstart, bgoal;
  logic [15:0]        ticks;
  logic [20:0]        dt;
  logic [66:0]        prod;
  logic [47:0]        blen, belap;
  logic               brun;
  logic signed [33:0] nv;
  logic [31:0]        w0, w;

  // shared multiplier operands
  logic [34:0] ma;
  logic [31:0] mb;
  logic [34:0] jerk;

  logic signed [33:0] err, err_abs, gdiff, gdiff_abs, trap_mc, dmag, nvt, ms, ms_neg;
  logic signed [32:0] bdiff;
  logic [31:0]        bdv_abs, accel_abs;
  logic signed [35:0] a36, want, acc36, aerr, mac, an;
  logic [48:0]        el_sum;
  logic [PW-1:0]      pos;
  logic [PW-1:0]      qidx;
  logic [CW-1:0]      idx;
  logic [31:0]        wdiff;
  logic [32:0]        mag;

  // divider
  logic               div_start, div_done;
  logic [DVD_W-1:0]   div_dvd, div_q;
  logic [DVS_W-1:0]   div_dvs;

  assign jerk      = (jerk_lim != '0) ? 35'(jerk_lim) : 35'(accel_lim) * 35'd10;
  assign err       = 34'(tgt) - 34'(speed);
  assign err_abs   = err[33] ? -err : err;
  assign gdiff     = 34'(tgt) - 34'(bgoal);
  assign gdiff_abs = gdiff[33] ? -gdiff : gdiff;
  assign bdiff     = 33'(bgoal) - 33'(bstart);
  assign bdv_abs   = bdiff[32] ? 32'(-bdiff) : bdiff[31:0];
  assign accel_abs = accel[31] ? 32'(-accel) : 32'(accel);
  assign trap_mc   = $signed({2'b00, prod[55:24]});
  assign dmag      = $signed({2'b00, prod[55:24]});
  assign nvt       = accel[31] ? 34'(speed) - dmag : 34'(speed) + dmag;
  assign ms        = $signed({3'b000, speed_lim});
  assign ms_neg    = -ms;

  assign a36   = $signed(36'(accel_lim));
  assign want  = (err_abs < SMALL_Q16) ? 36'sd0 : (err > 34'sd0 ? a36 : -a36);
  assign acc36 = 36'(accel);
  assign aerr  = want - acc36;
  assign mac   = $signed({2'b00, prod[57:24]});
  always_comb begin
    if (aerr > mac) an = acc36 + mac;
    else if (aerr < -mac) an = acc36 - mac;
    else an = want;
    if (an > a36) an = a36;
    if (an < -a36) an = -a36;
  end

  assign el_sum = {1'b0, belap} + 49'(dt);
  assign pos    = PW'(belap) * N_MUL;
  assign qidx   = div_q[DVD_W-1:16];
  assign idx    = (qidx >= PW'(COS_TABLE_ENTRIES)) ? IDX_LAST : qidx[CW-1:0];
  assign wdiff  = (wtab[idx + 1'b1] > wtab[idx]) ? wtab[idx + 1'b1] - wtab[idx] : 32'd0;
  assign mag    = prod[62:30];

  always_comb begin
    unique case (cmd.step)
      ST_DT_MUL: begin ma = 35'(ticks);     mb = 32'(tick_period); end
      ST_T_MUL:  begin ma = 35'(accel_lim); mb = 32'(dt);          end
      ST_J_MUL:  begin ma = jerk;           mb = 32'(dt);          end
      ST_D_MUL:  begin ma = 35'(accel_abs); mb = 32'(dt);          end
      ST_L_MUL:  begin ma = 35'(bdv_abs);   mb = PI_Q30;           end
      ST_C_INT:  begin ma = 35'(wdiff);     mb = 32'(div_q[15:0]); end
      ST_C_MAG:  begin ma = 35'(bdv_abs);   mb = w;                end
      default:   begin ma = '0;             mb = '0;               end
    endcase
  end

  assign div_start = (cmd.step == ST_L_DIV) || (cmd.step == ST_P_DIV);
  assign div_dvd   = (cmd.step == ST_L_DIV) ? DVD_W'(prod[63:0]) : {pos, 16'd0};
  assign div_dvs   = (cmd.step == ST_L_DIV) ? {10'd0, accel_lim, 7'd0} : blen;

  vpr_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .done    (div_done),
    .quotient(div_q)
  );

  assign stat.dt_zero    = (prod[39:0] == '0);
  assign stat.mode       = mode;
  assign stat.jerk_zero  = (jerk_lim == '0) && (accel_lim == '0);
  assign stat.accel_zero = (accel_lim == '0);
  assign stat.restart    = (gdiff_abs >= SMALL_Q16) || !brun;
  assign stat.dv_small   = (err_abs < SMALL_Q16);
  assign stat.len_zero   = (blen == '0);
  assign stat.el_done    = (belap >= blen);
  assign stat.div_done   = div_done;

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_TRAP;
      accel_lim   <= 31'd2621440;
      jerk_lim    <= 31'd0;
      speed_lim   <= 31'd327680000;
      tick_period <= 24'd16777;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:   mode        <= cfg_data[1:0];
        CFG_ACCEL:  accel_lim   <= cfg_data;
        CFG_JERK:   jerk_lim    <= cfg_data;
        CFG_SPEED:  speed_lim   <= cfg_data;
        CFG_PERIOD: tick_period <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= speed;
    case (cmd.step) inside
      ST_LATCH: begin
        tgt   <= in_data[31:0];
        ticks <= in_data[47:32];
      end
      ST_DT_MUL, ST_T_MUL, ST_J_MUL, ST_D_MUL, ST_L_MUL, ST_C_MAG:
        prod <= 67'(ma) * 67'(mb);
      ST_DT_SAT: dt <= (prod[39:0] > 40'(DT_LIMIT)) ? DT_LIMIT : prod[20:0];
      ST_TRAP: begin
        if (err > trap_mc) nv <= 34'(speed) + trap_mc;
        else if (err < -trap_mc) nv <= 34'(speed) - trap_mc;
        else nv <= 34'(tgt);
      end
      ST_S_NV: begin
        if ((err > 34'sd0 && nvt > 34'(tgt)) || (err < 34'sd0 && nvt < 34'(tgt))) nv <= 34'(tgt);
        else if (nvt > NV_MAX) nv <= NV_MAX;
        else if (nvt < NV_MIN) nv <= NV_MIN;
        else nv <= nvt;
      end
      ST_C_ADV: if (blen == '0) nv <= 34'(tgt);
      ST_C_CMP: if (belap >= blen) nv <= 34'(bgoal);
      // interpolation product and lower table weight together
      ST_C_INT: begin
        prod <= 67'(ma) * 67'(mb);
        w0   <= wtab[idx];
      end
      ST_C_W:   w  <= w0 + prod[47:16];
      ST_C_NV:  nv <= bdiff[32] ? 34'(bstart) - $signed({1'b0, mag})
                                : 34'(bstart) + $signed({1'b0, mag});
      default: ;
    endcase
  end

  // profile state
  always_ff @(posedge clk) begin
    if (rst) begin
      speed  <= '0;
      accel  <= '0;
      bstart <= '0;
      bgoal  <= '0;
      blen   <= '0;
      belap  <= '0;
      brun   <= 1'b0;
    end else begin
      case (cmd.step)
        ST_TRAP:  if (mode == MODE_SCURVE) accel <= '0;
        ST_J_ACC: accel <= an[31:0];
        ST_S_NV: begin
          if ((err > 34'sd0 && nvt > 34'(tgt)) || (err < 34'sd0 && nvt < 34'(tgt)))
            accel <= '0;
        end
        ST_C_CHK: begin
          if (stat.restart) begin
            bstart <= speed;
            bgoal  <= tgt;
            belap  <= '0;
            brun   <= 1'b1;
            if (stat.dv_small) blen <= '0;
            else if (stat.accel_zero) blen <= LEN_MAX;
          end
        end
        ST_L_SET: blen <= (div_q[DVD_W-1:48] != '0) ? LEN_MAX : div_q[47:0];
        ST_C_ADV: begin
          if (blen == '0) brun <= 1'b0;
          else belap <= el_sum[48] ? LEN_MAX : el_sum[47:0];
        end
        ST_C_CMP: if (belap >= blen) brun <= 1'b0;
        ST_LIMIT: begin
          if (speed_lim == '0) speed <= nv[31:0];
          else if (nv > ms) speed <= ms[31:0];
          else if (nv < ms_neg) speed <= ms_neg[31:0];
          else speed <= nv[31:0];
        end
        default: ;
      endcase
    end
  end

endmodule

@@ src/velocity_profile_ramp_top.sv @@
// ----------------------------------------------------------------------------
// velocity_profile_ramp_top: one axis of a jerk-limited velocity ramp
// Trapezoid, cosine blend or S-curve speed setpoint stepping with speed limit.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  s_*     | in  | s_tvalid / s_tready | target, tick count
//  m_*     | out | m_tvalid / m_tready | speed_out
//  cfg_*   | in  | cfg_we              | cfg_index, cfg_data
//
// One transaction at a time through a sequencer, a shared 35x32 multiplier and a
// restoring divider with a DVD_W = 73 bit dividend at 256 table entries.
// Zero step time skips the profile; a cosine step that ends its blend needs no
// division, a mid-blend step one and a step that restarts a blend up to two.
// Reset (rst, synchronous) clears state and loads register defaults; no sweep.
// The result sits in an output register, so the next transaction is taken while
// it waits; a stalled output blocks only the end of the following item.
// ----------------------------------------------------------------------------
module velocity_profile_ramp_top
  import vpr_pkg::*;
#(
  parameter int COS_TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [31:0] target, [47:32] tick count
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] speed_out
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: handshakes and step order
  vpr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // arithmetic, config and profile state
  vpr_dp #(
    .COS_TABLE_ENTRIES(COS_TABLE_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (m_tdata)
  );

endmodule

@@ test/velocity_profile_ramp_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// velocity_profile_ramp_top_test: self-checking bench for one ramp axis
// Drives target/tick transactions through all profiles and register settings,
// predicts each speed with an in-bench fixed-point model, checks in order.
// ----------------------------------------------------------------------------
module velocity_profile_ramp_top_test
  import vpr_pkg::*;
;

  localparam int N_COS = 256;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // [31:0] target, [47:32] tick count
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] speed_out
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;

  velocity_profile_ramp_top #(.COS_TABLE_ENTRIES(N_COS)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Speed predictor: register copy, ramp state and blend weight table
  // ---------------------------------------------------------------------------
  logic [1:0]  mode_r;
  logic [30:0] accel_r, jerk_r, vmax_r;
  logic [23:0] period_r;

  longint          spd, acc, b_start, b_goal;
  longint unsigned b_len, b_el;
  bit              b_run;
  longint unsigned wtab [0:N_COS];

  logic [31:0] speed_q [$];    // expected speed_out, oldest first
  int  n_err = 0, n_items = 0, n_results = 0;
  bit  idle_on = 1'b1;
  int  hold_left = 0, gap_left = 0;

  function automatic longint absd(longint v);
    return v < 0 ? -v : v;
  endfunction

  // sin^2(pi*k/(2N)) in Q30 from a short Taylor series
  function automatic longint unsigned half_weight(longint unsigned k);
    longint unsigned x, t;
    longint s;
    x = (PI_Q30_W * k) / (2 * N_COS);
    t = x;
    s = longint'(x);
    for (int n = 1; n <= 4; n++) begin
      t = ((((t * x) >> 30) * x) >> 30) / ((2 * n) * (2 * n + 1));
      if (n & 1) s -= longint'(t); else s += longint'(t);
    end
    if (s < 0) s = 0;
    return (longint'(s) * longint'(s)) >> 30;
  endfunction

  function automatic void model_reset();
    for (int k = 0; k <= N_COS; k++)
      wtab[k] = (2 * k <= N_COS) ? half_weight(k) : ONE_Q30_W - half_weight(N_COS - k);
    mode_r = MODE_TRAP; accel_r = 31'd2621440; jerk_r = '0;
    vmax_r = 31'd327680000; period_r = 24'd16777;
    spd = 0; acc = 0; b_start = 0; b_goal = 0; b_len = 0; b_el = 0; b_run = 0;
  endfunction

  function automatic longint slew(longint cur, longint tgt, longint mc);
    longint d;
    d = tgt - cur;
    if (d > mc) return cur + mc;
    if (d < -mc) return cur - mc;
    return tgt;
  endfunction

  function automatic longint blend_step(longint tgt, longint unsigned dt);
    longint unsigned du, pos, idx, frac, w0, w1, w, mag, l;
    longint dv;
    if (absd(tgt - b_goal) >= SMALL_Q16 || !b_run) begin
      du = absd(tgt - spd);
      b_start = spd;
      b_goal = tgt;
      if (du >= SMALL_Q16) begin
        if (accel_r == 0) b_len = LEN_MAX;
        else begin
          l = (du * PI_Q30_W) / (longint'(accel_r) << 7);
          b_len = l > LEN_MAX ? LEN_MAX : l;
        end
      end else b_len = 0;
      b_el = 0;
      b_run = 1;
    end
    if (b_len == 0) begin
      b_run = 0;
      return tgt;
    end
    b_el += dt;
    if (b_el > LEN_MAX) b_el = LEN_MAX;
    if (b_el >= b_len) begin
      b_run = 0;
      return b_goal;
    end
    pos  = b_el * N_COS;
    idx  = pos / b_len;
    frac = ((pos % b_len) << 16) / b_len;
    if (idx >= N_COS) idx = N_COS - 1;
    w0 = wtab[idx];
    w1 = wtab[idx + 1];
    w  = w0 + (w1 > w0 ? (((w1 - w0) * frac) >> 16) : 0);
    dv = b_goal - b_start;
    du = absd(dv);
    mag = (du * w) >> 30;
    return dv < 0 ? b_start - longint'(mag) : b_start + longint'(mag);
  endfunction

  function automatic longint scurve(longint tgt, longint unsigned dt);
    longint a, err, want, aerr, mac, nv;
    longint unsigned jk, dmag;
    a  = accel_r;
    jk = (jerk_r != 0) ? longint'(jerk_r) : 10 * longint'(accel_r);
    if (jk == 0) begin
      acc = 0;
      return slew(spd, tgt, longint'((longint'(accel_r) * dt) >> 24));
    end
    err  = tgt - spd;
    want = absd(err) < SMALL_Q16 ? 0 : (err > 0 ? a : -a);
    aerr = want - acc;
    mac  = longint'((jk * dt) >> 24);
    if (aerr > mac) acc += mac;
    else if (aerr < -mac) acc -= mac;
    else acc = want;
    if (acc > a) acc = a;
    if (acc < -a) acc = -a;
    dmag = (longint'(absd(acc)) * dt) >> 24;
    nv = acc < 0 ? spd - longint'(dmag) : spd + longint'(dmag);
    if ((err > 0 && nv > tgt) || (err < 0 && nv < tgt)) begin
      nv = tgt;
      acc = 0;
    end
    if (nv > 64'sd2147483647) nv = 64'sd2147483647;
    if (nv < -64'sd2147483648) nv = -64'sd2147483648;
    return nv;
  endfunction

  function automatic logic [31:0] next_speed(logic [31:0] tgt_bits, logic [15:0] ticks);
    longint tgt, nv, m;
    longint unsigned dt;
    tgt = longint'(signed'(tgt_bits));
    dt  = longint'(ticks) * longint'(period_r);
    if (dt > DT_LIMIT) dt = DT_LIMIT;
    if (dt != 0) begin
      if (mode_r == MODE_COSINE) nv = blend_step(tgt, dt);
      else if (mode_r == MODE_SCURVE) nv = scurve(tgt, dt);
      else nv = slew(spd, tgt, longint'((longint'(accel_r) * dt) >> 24));
      m = vmax_r;
      if (m != 0) begin
        if (nv > m) nv = m;
        else if (nv < -m) nv = -m;
      end
      spd = nv;
    end
    return spd[31:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: ready with random stall bursts, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (gap_left > 0) begin
      m_tready <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      gap_left <= $urandom_range(0, 3);
    end else m_tready <= 1'b1;
  end

  // result checker: every output transaction against the oldest prediction
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (speed_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("ERROR: unexpected speed_out %h", m_tdata);
      end else begin
        want = speed_q.pop_front();
        if (m_tdata !== want) begin
          n_err++;
          if (n_err <= 10)
            $display("ERROR: speed_out exp %h (%0d) got %h (%0d)",
                     want, signed'(want), m_tdata, signed'(m_tdata));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // one input transaction; valid stays up unless an idle burst follows
  task automatic send(logic [31:0] tgt, logic [15:0] ticks);
    s_tdata  <= {ticks, tgt};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    speed_q.push_back(next_speed(tgt, ticks));
    n_items++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // wait out every pending result plus the worst-case sequencer time
  task automatic drain();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (speed_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  // full register set while idle, plus a write past the register list
  task automatic apply_cfg(logic [1:0] md, logic [30:0] a, logic [30:0] j,
                           logic [30:0] vm, logic [23:0] per);
    logic [2:0]  idx [0:5];
    logic [30:0] val [0:5];
    drain();
    idx = '{CFG_MODE, CFG_ACCEL, CFG_JERK, CFG_SPEED, CFG_PERIOD,
            3'($urandom_range(5, 7))};
    val = '{31'(md), a, j, vm, 31'(per), 31'($urandom)};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    mode_r = md; accel_r = a; jerk_r = j; vmax_r = vm; period_r = per;
  endtask

  function automatic logic [31:0] rand_speed();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000);
  endfunction

  function automatic logic [15:0] rand_ticks();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return 16'($urandom);
      2:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 30));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------
  // register defaults, zero step time, long step saturation, extreme targets
  task automatic test_trapezoid();
    send(32'h7FFF_FFFF, 16'd1);
    send(32'h7FFF_FFFF, 16'd0);
    send(32'h8000_0000, 16'hFFFF);
    send(32'h0001_0000, 16'd5);
    apply_cfg(MODE_TRAP_ALT, 31'h7FFF_FFFF, '0, '0, 24'hFF_FFFF);
    send(32'h8000_0000, 16'd1);
    send(32'h7FFF_FFFF, 16'hFFFF);
  endtask

  // blend restarts, in-flight blends, zero length jump, zero accel
  task automatic test_cosine();
    apply_cfg(MODE_COSINE, 31'd2621440, '0, 31'd327680000, 24'd16777);
    send(32'h0010_0000, 16'd10);
    send(32'h0010_0000, 16'd50);
    send(32'h0010_0010, 16'd100);
    send(32'hFFF0_0000, 16'd20);
    send(32'hFFF0_0000, 16'hFFFF);
    send(32'hFFF0_0020, 16'd3);
    apply_cfg(MODE_COSINE, '0, '0, 31'd327680000, 24'd16777);
    send(32'h0100_0000, 16'd10);
  endtask

  // jerk from accel, explicit jerk, overshoot clamp, zero accel
  task automatic test_scurve();
    apply_cfg(MODE_SCURVE, 31'd2621440, '0, 31'd327680000, 24'd16777);
    send(32'h0004_0000, 16'd20);
    send(32'h0004_0000, 16'd100);
    send(32'hFFFC_0000, 16'd50);
    apply_cfg(MODE_SCURVE, 31'h7FFF_FFFF, 31'h7FFF_FFFF, '0, 24'hFF_FFFF);
    send(32'h7FFF_FFFF, 16'd1);
    send(32'h8000_0000, 16'd1);
    apply_cfg(MODE_SCURVE, '0, '0, 31'd66, 24'd1);
    send(32'h0000_1000, 16'd7);
  endtask

  // output held off for a long time while input keeps coming
  task automatic test_backpressure();
    apply_cfg(MODE_TRAP, 31'd2621440, '0, 31'd327680000, 24'd16777);
    hold_left <= 400;
    for (int i = 0; i < 8; i++) send(rand_speed(), rand_ticks());
  endtask

  // random register phases, targets held for a few updates so profiles develop
  task automatic test_random();
    logic [30:0] a, j, vm;
    logic [23:0] per;
    logic [31:0] tgt;
    int left, run;
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 5))
        0:       a = '0;
        1:       a = 31'h7FFF_FFFF;
        default: a = 31'($urandom_range(32'h1_0000, 32'h400_0000));
      endcase
      j   = ($urandom_range(0, 2) == 0) ? '0 :
            ($urandom_range(0, 4) == 0) ? 31'h7FFF_FFFF : 31'($urandom_range(1, 32'h4000_0000));
      vm  = ($urandom_range(0, 3) == 0) ? '0 :
            ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(32'h10_0000, 32'h1000_0000));
      per = ($urandom_range(0, 7) == 0) ? 24'($urandom) :
            ($urandom_range(0, 9) == 0) ? 24'hFF_FFFF : 24'($urandom_range(1000, 40000));
      if (ph == 11) idle_on = 1'b0;
      apply_cfg(2'(ph % 4 == 3 ? $urandom_range(0, 3) : ph % 4), a, j, vm, per);
      left = 150;
      while (left > 0) begin
        tgt = rand_speed();
        run = $urandom_range(1, 12);
        for (int k = 0; k < run && left > 0; k++, left--) begin
          if ($urandom_range(0, 7) == 0) tgt = tgt + 32'($urandom_range(0, 130)) - 32'd65;
          send(tgt, rand_ticks());
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_trapezoid();
    test_cosine();
    test_scurve();
    test_backpressure();
    test_random();
    drain();
    $display("Covered %0d transactions, %0d results: trapezoid, cosine blend and S-curve",
             n_items, n_results);
    $display("profiles under random register phases, extremes and output back-pressure.");
    if (n_err == 0 && speed_q.size() == 0) begin
      $display("PASS velocity_profile_ramp_top");
    end else begin
      $display("%0d mismatches, %0d results missing", n_err, speed_q.size());
      $display("FAIL velocity_profile_ramp_top");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #40_000_000;
    $display("FAIL velocity_profile_ramp_top");
    $finish;
  end

endmodule
